/* design/lia_rs_pkg.sv */
package lia_rs_pkg;

  // sample and phase formats
  localparam int SAMPLE_W  = 16;
  localparam int FRAC_W    = 16;
  localparam int PHASE_W   = FRAC_W + 6;
  localparam int STEP_W    = 22;
  localparam int CFG_DATA_W = 22;
  localparam int CFG_IDX_W = 1;

  // interpolation numerator: prev * 2^FRAC_W + diff * phase
  localparam int NUM_W = SAMPLE_W + FRAC_W + 2;

  // phase constants
  localparam logic [PHASE_W:0] PHASE_ONE = (PHASE_W + 1)'(1) << FRAC_W;
  localparam logic [STEP_W-1:0] STEP_MIN = STEP_W'(1) << (FRAC_W - 6);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1) << FRAC_W;

  // half of full scale times one, for the rounding correction
  localparam logic signed [NUM_W-1:0] ROUND_HALF =
    NUM_W'(1) << (SAMPLE_W + FRAC_W - 2);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = CFG_IDX_W'(1);

  // controller to datapath commands
  typedef struct packed {
    logic latch;   // take the incoming word
    logic first;   // store the first sample
    logic skip;    // no output, phase drops by one
    logic mul;     // diff times phase, phase advance
    logic sum;     // add prev term
    logic rnd1;    // magnitude and sign
    logic rnd2;    // scale and round
    logic load;    // load the output register
    logic finish;  // wrap phase, move sample to prev
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic bypass;
    logic have_prev;
    logic phase_ge_one;
    logic out_free;
  } sts_t;

endpackage

/* design/lia_rs_ctrl.sv */
module lia_rs_ctrl
  import lia_rs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_RND1,
    S_RND2,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   ready_q, ready_d;
  logic   accept;

  assign accept     = in_valid_i && ready_q;
  assign in_ready_o = ready_q;

  // command decode and next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    ready_d = ready_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.latch = 1'b1;
          if (sts_i.bypass) begin
            state_d = S_EMIT;
            ready_d = 1'b0;
          end else if (!sts_i.have_prev) begin
            cmd_o.first = 1'b1;
          end else if (sts_i.phase_ge_one) begin
            cmd_o.skip = 1'b1;
          end else begin
            state_d = S_MUL;
            ready_d = 1'b0;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_RND1;
      end
      S_RND1: begin
        cmd_o.rnd1 = 1'b1;
        state_d    = S_RND2;
      end
      S_RND2: begin
        cmd_o.rnd2 = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          if (sts_i.bypass) begin
            state_d = S_IDLE;
            ready_d = 1'b1;
          end else if (sts_i.phase_ge_one) begin
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
            ready_d      = 1'b1;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
        ready_d = 1'b1;
      end
    endcase
  end

  // state and registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
    end
  end

endmodule

/* design/lia_rs_dp.sv */
module lia_rs_dp
  import lia_rs_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  input  logic signed [SAMPLE_W-1:0]  sample_in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [SAMPLE_W-1:0]  sample_out_o,
  output logic                        last_of_run_o,
  input  cmd_t                        cmd_i,
  output sts_t                        sts_o
);

  // configuration
  logic              bypass_q;
  logic [STEP_W-1:0] step_q;

  // resampler state
  logic signed [SAMPLE_W-1:0] prev_q;
  logic                       have_prev_q;
  logic [PHASE_W:0]           phase_q, phase_d;

  // working registers
  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [SAMPLE_W:0]   diff_q;
  logic signed [NUM_W-1:0]    prod_q, num_q, mag_q;
  logic                       neg_q;
  logic [SAMPLE_W-1:0]        m2_q;

  // output register
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_q;
  logic                       last_q;

  logic [STEP_W-1:0]          step_eff;
  logic [PHASE_W:0]           phase_wrap;
  logic signed [NUM_W-1:0]    prod_d, num_d, err, err_fl, scaled;
  logic signed [SAMPLE_W-1:0] res;
  logic                       ge_one;

  // small step clamped so at most 64 words per sample
  assign step_eff   = (step_q < STEP_MIN) ? STEP_MIN : step_q;
  assign ge_one     = |phase_q[PHASE_W:FRAC_W];
  assign phase_wrap = {1'b0, phase_q[PHASE_W-1:0] - PHASE_ONE[PHASE_W-1:0]};

  // diff times phase fraction
  assign prod_d = NUM_W'(diff_q) * NUM_W'($signed({1'b0, phase_q[FRAC_W-1:0]}));
  assign num_d  = $signed({{2{prev_q[SAMPLE_W-1]}}, prev_q, {FRAC_W{1'b0}}}) + prod_q;

  // scale by (FS-1)/FS with rounding half away from zero
  assign err    = ROUND_HALF - mag_q;
  assign err_fl = err >>> (SAMPLE_W - 1);
  assign scaled = mag_q + err_fl;
  assign res    = neg_q ? -$signed(m2_q) : $signed(m2_q);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q <= 1'b1;
      step_q   <= STEP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BYPASS: bypass_q <= cfg_data_i[0];
        CFG_STEP:   step_q   <= cfg_data_i[STEP_W-1:0];
        default:    ;
      endcase
    end
  end

  // phase next value
  always_comb begin
    phase_d = phase_q;
    if (cmd_i.skip || cmd_i.finish) begin
      phase_d = phase_wrap;
    end else if (cmd_i.mul) begin
      phase_d = phase_q + {1'b0, step_eff};
    end
  end

  // resampler state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      phase_q     <= '0;
    end else begin
      phase_q <= phase_d;
      if (cmd_i.first) begin
        prev_q      <= sample_in_i;
        have_prev_q <= 1'b1;
      end else if (cmd_i.skip) begin
        prev_q <= sample_in_i;
      end else if (cmd_i.finish) begin
        prev_q <= x_q;
      end
    end
  end

  // arithmetic pipeline registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      x_q    <= sample_in_i;
      diff_q <= $signed({sample_in_i[SAMPLE_W-1], sample_in_i})
              - $signed({prev_q[SAMPLE_W-1], prev_q});
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.sum) begin
      num_q <= num_d;
    end
    if (cmd_i.rnd1) begin
      neg_q <= num_q[NUM_W-1];
      mag_q <= num_q[NUM_W-1] ? -num_q : num_q;
    end
    if (cmd_i.rnd2) begin
      m2_q <= scaled[FRAC_W +: SAMPLE_W];
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q  <= bypass_q ? x_q : res;
      last_q <= bypass_q | ge_one;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = out_q;
  assign last_of_run_o = last_q;

  // status
  assign sts_o.bypass       = bypass_q;
  assign sts_o.have_prev    = have_prev_q;
  assign sts_o.phase_ge_one = ge_one;
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

endmodule

/* design/linear_interp_audio_resampler.sv */
// Linear interpolation audio resampler
// Input channel: in_valid_i / in_ready_o with sample_in_i, one signed word
// per handshake at the input rate. Output channel: out_valid_o / out_ready_i
// with sample_out_o and last_of_run_o; last_of_run_o marks the final word
// caused by one input word.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 bypass, 1 step ratio in Q6.16); the user writes it only while the block
// is idle, which the block itself does not enforce. In bypass each input
// word gives one output word, latched and then loaded into the output
// register. Otherwise the first input word is only stored, and each later
// one gives zero to 64 words; every interpolated word passes through a
// multiply, add, magnitude and rounding step before the output register.
// A word that gives no output is done at acceptance; ready stays high.
// The next input word is taken once the last output word of the current
// one sits in the output register, even while that word waits.
// When the receiver stalls, the output register holds and the controller
// waits before loading the next word.
// Reset clears the previous sample, its flag and the phase, sets bypass
// and a step ratio of one, and empties the output register.
module linear_interp_audio_resampler
  import lia_rs_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  output logic                       last_of_run_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  lia_rs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic and state
  lia_rs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .sample_in_i   (sample_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sample_out_o  (sample_out_o),
    .last_of_run_o (last_of_run_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule
